// ----- design/fp64_fmod_pkg.sv -----
// package for the fp64 remainder unit: constants and state codes
package fp64_fmod_pkg;
  localparam logic [63:0] QNAN_BITS  = 64'h7FF8000000000000;
  localparam logic [63:0] INF_BITS   = 64'h7FF0000000000000;
  localparam logic [63:0] ABS_MASK   = 64'h7FFFFFFFFFFFFFFF;
  localparam logic [63:0] SIGN_MASK  = 64'h8000000000000000;
  localparam logic [51:0] FRAC_MASK  = 52'hFFFFFFFFFFFFF;
  localparam int          EXP_W      = 13;
  localparam int          SIG_W      = 54;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_NORMX = 3'd1;
  localparam logic [2:0] ST_NORMY = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_NORMR = 3'd4;
  localparam logic [2:0] ST_DENRM = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;
endpackage

// ----- design/fp64_remainder_fmod_unit.sv -----
// fp64 fmod unit: shift-subtract remainder of two binary64 words
// operation: special cases go straight to the done state; otherwise subnormal operands are
//   normalized, the shift-subtract loop runs over the exponent difference, then the result is
//   normalized or denormalized; one bit per cycle
// throughput: one word at a time, busy high for the whole operation
// reset: synchronous active-low rst_n clears the sequencer and out_valid
module fp64_remainder_fmod_unit import fp64_fmod_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_dividend_bits,
  input  logic [63:0] in_divisor_bits,
  output logic        out_valid,
  output logic [63:0] out_remainder_bits
);
  logic [2:0]            state_r, state_nxt;
  logic [SIG_W-1:0]      mx_r, mx_nxt;
  logic [52:0]           my_r, my_nxt;
  logic signed [EXP_W-1:0] ex_r, ex_nxt, ey_r, ey_nxt;
  logic [63:0]           sign_r, sign_nxt;
  logic [63:0]           res_r, res_nxt;
  logic                  valid_nxt;

  // subtract/compare unit for the divide loop
  logic [SIG_W:0] diff;
  logic           ge;
  assign diff = {1'b0, mx_r} - {2'b0, my_r};
  assign ge   = !diff[SIG_W];

  logic [63:0] ax, ay;
  assign ax = in_dividend_bits & ABS_MASK;
  assign ay = in_divisor_bits & ABS_MASK;

  assign busy = (state_r != ST_IDLE);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    mx_nxt = mx_r; my_nxt = my_r; ex_nxt = ex_r; ey_nxt = ey_r;
    sign_nxt = sign_r; res_nxt = res_r; valid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          sign_nxt = in_dividend_bits & SIGN_MASK;
          mx_nxt = {1'b0, (ax[62:52] != 11'd0), ax[51:0]};
          my_nxt = {(ay[62:52] != 11'd0), ay[51:0]};
          ex_nxt = (ax[62:52] == 11'd0) ? EXP_W'(1) : EXP_W'({2'b0, ax[62:52]});
          ey_nxt = (ay[62:52] == 11'd0) ? EXP_W'(1) : EXP_W'({2'b0, ay[62:52]});
          if (ax > INF_BITS || ay > INF_BITS || ax == INF_BITS || ay == 64'd0) begin
            res_nxt = QNAN_BITS; state_nxt = ST_DONE;
          end else if (ay == INF_BITS || ax < ay) begin
            res_nxt = in_dividend_bits; state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_NORMX;
          end
        end
      end
      ST_NORMX: begin
        if (mx_r[52]) state_nxt = ST_NORMY;
        else begin mx_nxt = mx_r << 1; ex_nxt = ex_r - EXP_W'(1); end
      end
      ST_NORMY: begin
        if (my_r[52]) state_nxt = ST_DIV;
        else begin my_nxt = my_r << 1; ey_nxt = ey_r - EXP_W'(1); end
      end
      ST_DIV: begin
        if (ex_r > ey_r) begin
          mx_nxt = (ge ? diff[SIG_W-1:0] : mx_r) << 1;
          ex_nxt = ex_r - EXP_W'(1);
        end else begin
          mx_nxt = ge ? diff[SIG_W-1:0] : mx_r;
          state_nxt = ST_NORMR;
        end
      end
      ST_NORMR: begin
        if (mx_r == '0) begin
          res_nxt = sign_r; state_nxt = ST_DONE;
        end else if (!mx_r[52]) begin
          mx_nxt = mx_r << 1; ey_nxt = ey_r - EXP_W'(1);
        end else if (ey_r >= EXP_W'(1)) begin
          res_nxt = sign_r | {1'b0, ey_r[10:0], mx_r[51:0]};
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_DENRM;
        end
      end
      ST_DENRM: begin
        // shift right until exponent reaches 1
        if (ey_r < EXP_W'(1)) begin
          mx_nxt = mx_r >> 1; ey_nxt = ey_r + EXP_W'(1);
        end else begin
          res_nxt = sign_r | {11'd0, mx_r[52:0]};
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        valid_nxt = 1'b1; state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid <= valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    mx_r <= mx_nxt; my_r <= my_nxt; ex_r <= ex_nxt; ey_r <= ey_nxt;
    sign_r <= sign_nxt; res_r <= res_nxt;
  end

  assign out_remainder_bits = res_r;

  // result strobe only leaving the done state
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r) == ST_DONE) else $error("stray strobe");
  // no new word taken while busy
  assert property (@(posedge clk) disable iff (!rst_n)
    (busy && state_r != ST_DONE) |=> busy) else $error("busy dropped early");
  // divide loop keeps mx below twice my whenever the top bit of mx is set
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> mx_r[53] == 1'b0 || mx_r < {my_r, 1'b0})
    else $error("remainder invariant broken");
endmodule

// ----- tb/tb_fp64_remainder_fmod_unit.sv -----
// testbench for the fp64 remainder unit: directed and random words checked against a predictor
`timescale 1ns / 1ps

module tb_fp64_remainder_fmod_unit import fp64_fmod_pkg::*;;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [63:0] in_dividend_bits;
  logic [63:0] in_divisor_bits;
  logic        out_valid;
  logic [63:0] out_remainder_bits;

  logic [63:0] rem_expected_q[$];
  int          fail_count;
  int          cycle_count;
  int          send_idle_pct;

  localparam int CYCLE_LIMIT = 4000000;

  fp64_remainder_fmod_unit i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_dividend_bits(in_dividend_bits), .in_divisor_bits(in_divisor_bits),
    .out_valid(out_valid), .out_remainder_bits(out_remainder_bits)
  );

  // clock, 12 ns period
  always begin
    clk = 1'b0; #6;
    clk = 1'b1; #6;
  end

  // normalize a finite nonzero magnitude to a 53-bit significand
  task automatic split_mag(input logic [63:0] mag, output logic [63:0] sig,
                           output int expo);
    int e;
    logic [63:0] m;
    e = int'(mag[62:52]);
    m = {12'd0, mag[51:0]};
    if (e == 0) begin
      e = 1;
      while (m[52] == 1'b0) begin
        m = m << 1;
        e--;
      end
    end else begin
      m[52] = 1'b1;
    end
    sig = m;
    expo = e;
  endtask

  // expected fmod bit pattern
  task automatic predict_fmod(input logic [63:0] xb, input logic [63:0] yb,
                              output logic [63:0] r);
    logic [63:0] sgn, ax, ay, mx, my;
    int ex, ey, sh;
    sgn = xb & SIGN_MASK;
    ax = xb & ABS_MASK;
    ay = yb & ABS_MASK;
    if (ax > INF_BITS || ay > INF_BITS || ax == INF_BITS || ay == 64'd0) begin
      r = QNAN_BITS;
    end else if (ay == INF_BITS || ax < ay) begin
      r = xb;
    end else begin
      split_mag(ax, mx, ex);
      split_mag(ay, my, ey);
      while (ex > ey) begin
        if (mx >= my) mx = mx - my;
        mx = mx << 1;
        ex--;
      end
      if (mx >= my) mx = mx - my;
      if (mx == 64'd0) begin
        r = sgn;
      end else begin
        while (mx[52] == 1'b0) begin
          mx = mx << 1;
          ey--;
        end
        if (ey >= 1) begin
          r = sgn | (64'(ey) << 52) | {12'd0, mx[51:0]};
        end else begin
          sh = 1 - ey;
          r = (sh > 63) ? sgn : (sgn | (mx >> sh));
        end
      end
    end
  endtask

  // send one word, with random idle cycles ahead of it
  task automatic send_word(input logic [63:0] x, input logic [63:0] y);
    logic [63:0] r;
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    start <= 1'b1;
    in_dividend_bits <= x;
    in_divisor_bits <= y;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_fmod(x, y, r);
    rem_expected_q.push_back(r);
    start <= 1'b0;
    in_dividend_bits <= {$urandom, $urandom};
    in_divisor_bits <= {$urandom, $urandom};
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (rem_expected_q.size() != 0) @(posedge clk);
  endtask

  // random double biased toward interesting exponents
  function automatic logic [63:0] rand_double();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(9))
      0: v[62:52] = 11'd0;
      1: v[62:52] = 11'h7FF;
      2: v[62:52] = 11'($urandom_range(3));
      3: v[62:0] = 63'($urandom_range(15));
      default: v[62:52] = 11'($urandom_range(1023 + 40, 1023 - 40));
    endcase
    return v;
  endfunction

  // result checker
  always @(posedge clk) begin
    if (rst_n) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
      if (out_valid) begin
        if (rem_expected_q.size() == 0) begin
          $error("remainder_bits: unexpected word, actual %h", out_remainder_bits);
          fail_count++;
        end else begin
          if (out_remainder_bits !== rem_expected_q[0]) begin
            $error("remainder_bits: expected %h actual %h", rem_expected_q[0],
                   out_remainder_bits);
            fail_count++;
          end
          void'(rem_expected_q.pop_front());
        end
      end
    end
  end

  task automatic test_special_cases();
    send_word(64'h7FF8000000000001, 64'h3FF0000000000000);
    send_word(64'h3FF0000000000000, 64'hFFF0000000000001);
    send_word(64'h7FF0000000000000, 64'h3FF0000000000000);
    send_word(64'hFFF0000000000000, 64'h7FF0000000000000);
    send_word(64'h4000000000000000, 64'h0000000000000000);
    send_word(64'hC000000000000000, 64'h8000000000000000);
    send_word(64'h0000000000000000, 64'h0000000000000000);
    send_word(64'hC008000000000000, 64'h7FF0000000000000);
    send_word(64'h0000000000000000, 64'h3FF0000000000000);
    send_word(64'h8000000000000000, 64'h3FF0000000000000);
    send_word(64'h3FE0000000000000, 64'h3FF0000000000000);
  endtask

  task automatic test_exact_and_extreme();
    send_word(64'hC014000000000000, 64'hC014000000000000);
    send_word(64'h4024000000000000, 64'h4004000000000000);
    send_word(64'h7FEFFFFFFFFFFFFF, 64'h0000000000000001);
    send_word(64'h7FEFFFFFFFFFFFFF, 64'h000FFFFFFFFFFFFF);
    send_word(64'hFFEFFFFFFFFFFFFF, 64'h3FF8000000000000);
    send_word(64'h000FFFFFFFFFFFFF, 64'h0000000000000003);
    send_word(64'h0010000000000001, 64'h000FFFFFFFFFFFFF);
    send_word(64'h7FEFFFFFFFFFFFFF, 64'h7FEFFFFFFFFFFFFE);
    send_word(64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF);
    send_word(64'h4008000000000000, 64'h0010000000000000);
    send_word(64'h7FEFFFFFFFFFFFFF, 64'h8000000000000001);
  endtask

  task automatic test_random(input int n);
    logic [63:0] x;
    for (int i = 0; i < n; i++) begin
      x = rand_double();
      send_word(x, ($urandom_range(9) == 0) ? x ^ 64'(1) : rand_double());
      if (i == n / 2) wait_drained();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_dividend_bits = '0;
    in_divisor_bits = '0;
    fail_count = 0;
    cycle_count = 0;
    send_idle_pct = 7;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_special_cases();
    test_exact_and_extreme();
    test_random(90);
    send_idle_pct = 82;
    test_random(90);
    send_idle_pct = 0;
    test_random(90);
    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
design/fp64_fmod_pkg.sv
design/fp64_remainder_fmod_unit.sv
tb/tb_fp64_remainder_fmod_unit.sv
